@@ rtl/core/gnwg_pkg.sv @@
`default_nettype none
package gnwg_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned POS_W       = 18;
  localparam int unsigned HALF_W      = 17;
  localparam int unsigned WEIGHT_W    = 17;
  localparam int unsigned GRAD_W      = 25;
  localparam int unsigned SCALE_W     = 25;
  localparam int unsigned SLOPE_W     = 16;
  localparam int unsigned QUOT_W      = 16;
  localparam int unsigned DIV_STAGES  = QUOT_W;
  localparam int unsigned AXIS_LAT    = 3 + DIV_STAGES;
  localparam int unsigned PIPE_DEPTH  = AXIS_LAT + 2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(131072);

  typedef enum logic {
    CFG_X_SCALE = 1'b0,
    CFG_Y_SCALE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ZONE_INNER  = 2'd0,
    ZONE_LINEAR = 2'd1,
    ZONE_OUTER  = 2'd2,
    ZONE_NONE   = 2'd3
  } zone_e;

  typedef struct packed {
    logic [WEIGHT_W-1:0] s;
    logic [SLOPE_W-1:0]  ds;
    logic                side;
  } axis_res_t;

  localparam logic signed [2:0] NODE_OFF_X [16] = '{
    -3'sd1, 3'sd1, 3'sd1, -3'sd1, -3'sd3, -3'sd1, 3'sd1, 3'sd3,
    3'sd3, 3'sd3, 3'sd3, 3'sd1, -3'sd1, -3'sd3, -3'sd3, -3'sd3
  };
  localparam logic signed [2:0] NODE_OFF_Y [16] = '{
    -3'sd1, -3'sd1, 3'sd1, 3'sd1, -3'sd3, -3'sd3, -3'sd3, -3'sd3,
    -3'sd1, 3'sd1, 3'sd3, 3'sd3, 3'sd3, 3'sd3, 3'sd1, -3'sd1
  };

endpackage
`default_nettype wire

@@ rtl/core/gnwg_axis.sv @@
`default_nettype none
module gnwg_axis (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [gnwg_pkg::POS_W-1:0]   pos_i,
  input  wire logic [gnwg_pkg::HALF_W-1:0]         half_size_i,
  input  wire logic signed [2:0]                   off_i,
  output gnwg_pkg::axis_res_t                      res_o
);

  localparam int unsigned FB   = gnwg_pkg::FRAC_BITS;
  localparam int unsigned HW   = gnwg_pkg::HALF_W;
  localparam int unsigned SW   = 21;
  localparam int unsigned DW   = 19;
  localparam int unsigned BW   = 18;
  localparam int unsigned PW   = 36;
  localparam int unsigned RW   = 34;
  localparam int unsigned QW   = gnwg_pkg::QUOT_W;
  localparam int unsigned NS   = gnwg_pkg::DIV_STAGES;

  typedef struct packed {
    gnwg_pkg::zone_e zone;
    logic            side;
    logic [HW-1:0]   h;
    logic [HW-1:0]   lin;
    logic [RW-1:0]   rs;
    logic [RW-1:0]   rd;
    logic [QW-1:0]   qs;
    logic [QW-1:0]   qd;
  } dv_t;

  // stage 1: distance, zone
  logic signed [SW-1:0] ox;
  logic signed [SW-1:0] dxs;
  logic [SW-1:0]        dabs;
  logic [DW-1:0]        d;
  logic [HW-1:0]        hc;
  logic [DW-1:0]        q1, q2;
  gnwg_pkg::zone_e      zone1_d;
  logic [BW-1:0]        base1_d;
  logic [HW-1:0]        lin1_d;
  logic [DW-1:0]        lin_full;

  gnwg_pkg::zone_e      zone1_q, zone2_q, zone3_q;
  logic                 side1_q, side2_q, side3_q;
  logic [HW-1:0]        h1_q, h2_q, h3_q;
  logic [HW-1:0]        lin1_q, lin2_q, lin3_q;
  logic [BW-1:0]        base1_q;
  logic [PW-1:0]        sq2_q, hp2_q;
  logic [RW-1:0]        gd2_q;
  logic [RW-1:0]        rs3_d, rs3_q, rd3_q;

  logic signed [PW:0]   num;
  logic [18:0]          four_m_h;

  dv_t stg_q [NS];
  dv_t stg_d [NS];
  dv_t div_in [NS];

  always_comb begin
    ox   = {{(SW-3-FB){off_i[2]}}, off_i, {FB{1'b0}}};
    dxs  = SW'(pos_i) - ox;
    dabs = dxs[SW-1] ? SW'(-dxs) : SW'(dxs);
    d    = dabs[DW-1:0];
    hc   = (half_size_i == '0) ? HW'(1) : half_size_i;
    q1   = DW'(2 << FB) - DW'(hc);
    q2   = DW'(2 << FB) + DW'(hc);
    lin_full = (DW'(2 << FB) - d) >> 1;
    lin1_d   = lin_full[HW-1:0];
    if (d < DW'(hc)) begin
      zone1_d = gnwg_pkg::ZONE_INNER;
      base1_d = d[BW-1:0];
    end else if (d <= q1) begin
      zone1_d = gnwg_pkg::ZONE_LINEAR;
      base1_d = '0;
    end else if (d < q2) begin
      zone1_d = gnwg_pkg::ZONE_OUTER;
      base1_d = BW'(q2 - d);
    end else begin
      zone1_d = gnwg_pkg::ZONE_NONE;
      base1_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zone1_q <= zone1_d;
      side1_q <= (dxs > 0);
      h1_q    <= hc;
      lin1_q  <= lin1_d;
      base1_q <= base1_d;
    end
  end

  // stage 2: squares
  assign four_m_h = 19'(4 << FB) - 19'(h1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zone2_q <= zone1_q;
      side2_q <= side1_q;
      h2_q    <= h1_q;
      lin2_q  <= lin1_q;
      sq2_q   <= PW'(base1_q) * PW'(base1_q);
      hp2_q   <= PW'(four_m_h) * PW'(h1_q);
      gd2_q   <= (zone1_q == gnwg_pkg::ZONE_INNER) ? (RW'(base1_q) << (FB - 1))
                                                   : (RW'(base1_q) << (FB - 2));
    end
  end

  // stage 3: dividends over h
  always_comb begin
    num = $signed({1'b0, hp2_q}) - $signed({1'b0, sq2_q});
    case (zone2_q)
      gnwg_pkg::ZONE_INNER: rs3_d = (num > 0) ? RW'(num >>> 2) : '0;
      gnwg_pkg::ZONE_OUTER: rs3_d = RW'(sq2_q >> 3);
      default:              rs3_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zone3_q <= zone2_q;
      side3_q <= side2_q;
      h3_q    <= h2_q;
      lin3_q  <= lin2_q;
      rs3_q   <= rs3_d;
      rd3_q   <= gd2_q;
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        div_in[k] = '{zone: zone3_q, side: side3_q, h: h3_q, lin: lin3_q,
                      rs: rs3_q, rd: rd3_q, qs: '0, qd: '0};
      end else begin
        div_in[k] = stg_q[(k == 0) ? 0 : k - 1];
      end
    end
    for (int k = 0; k < NS; k++) begin
      stg_d[k] = div_in[k];
      if (div_in[k].rs >= (RW'(div_in[k].h) << (NS - 1 - k))) begin
        stg_d[k].rs = div_in[k].rs - (RW'(div_in[k].h) << (NS - 1 - k));
        stg_d[k].qs[NS-1-k] = 1'b1;
      end
      if (div_in[k].rd >= (RW'(div_in[k].h) << (NS - 1 - k))) begin
        stg_d[k].rd = div_in[k].rd - (RW'(div_in[k].h) << (NS - 1 - k));
        stg_d[k].qd[NS-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q <= stg_d;
    end
  end

  always_comb begin
    res_o.side = stg_q[NS-1].side;
    case (stg_q[NS-1].zone)
      gnwg_pkg::ZONE_INNER, gnwg_pkg::ZONE_OUTER: begin
        res_o.s  = HW'(stg_q[NS-1].qs);
        res_o.ds = stg_q[NS-1].qd;
      end
      gnwg_pkg::ZONE_LINEAR: begin
        res_o.s  = stg_q[NS-1].lin;
        res_o.ds = gnwg_pkg::SLOPE_W'(1 << (FB - 1));
      end
      default: begin
        res_o.s  = '0;
        res_o.ds = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/gnwg_back.sv @@
`default_nettype none
module gnwg_back (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire gnwg_pkg::axis_res_t                 ax_i,
  input  wire gnwg_pkg::axis_res_t                 ay_i,
  input  wire logic                                want_i,
  input  wire logic [gnwg_pkg::SCALE_W-1:0]        x_scale_i,
  input  wire logic [gnwg_pkg::SCALE_W-1:0]        y_scale_i,
  output logic [gnwg_pkg::WEIGHT_W-1:0]            weight_o,
  output logic signed [gnwg_pkg::GRAD_W-1:0]       grad_x_o,
  output logic signed [gnwg_pkg::GRAD_W-1:0]       grad_y_o
);

  localparam int unsigned FB = gnwg_pkg::FRAC_BITS;
  localparam int unsigned WW = gnwg_pkg::WEIGHT_W;
  localparam int unsigned GW = gnwg_pkg::GRAD_W;
  localparam int unsigned MW = gnwg_pkg::SLOPE_W;
  localparam int unsigned CW = gnwg_pkg::SCALE_W;
  localparam int unsigned PW = 2 * WW;
  localparam int unsigned GP = MW + CW;

  logic [PW-1:0]   wp, mxp, myp;
  logic [PW-FB-1:0] wsh;
  logic [WW-1:0]   w_q;
  logic [MW-1:0]   mx_q, my_q;
  logic            sx_q, sy_q, want_q;
  logic [GP-1:0]   gxp, gyp;
  logic [GW-1:0]   gxm, gym;
  logic [GW-2:0]   gxs, gys;

  always_comb begin
    wp  = PW'(ax_i.s) * PW'(ay_i.s);
    mxp = PW'(ax_i.ds) * PW'(ay_i.s);
    myp = PW'(ay_i.ds) * PW'(ax_i.s);
    wsh = wp[PW-1:FB];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q    <= (wsh > (PW-FB)'({WW{1'b1}})) ? {WW{1'b1}} : wsh[WW-1:0];
      mx_q   <= MW'(mxp >> FB);
      my_q   <= MW'(myp >> FB);
      sx_q   <= ax_i.side;
      sy_q   <= ay_i.side;
      want_q <= want_i;
    end
  end

  always_comb begin
    gxp = GP'(mx_q) * GP'(x_scale_i);
    gyp = GP'(my_q) * GP'(y_scale_i);
    gxm = gxp[FB +: GW];
    gym = gyp[FB +: GW];
    gxs = gxm[GW-1] ? {(GW-1){1'b1}} : gxm[GW-2:0];
    gys = gym[GW-1] ? {(GW-1){1'b1}} : gym[GW-2:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      weight_o <= w_q;
      grad_x_o <= !want_q ? '0 : (sx_q ? -$signed({1'b0, gxs}) : $signed({1'b0, gxs}));
      grad_y_o <= !want_q ? '0 : (sy_q ? -$signed({1'b0, gys}) : $signed({1'b0, gys}));
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/gimp_node_weight_gradient.sv @@
`default_nettype none
// GIMP node weight and gradient for one particle-node pair per transaction.
// One transaction is accepted every cycle while in_stall_o is low; each result
// passes through the 16-stage restoring dividers (one quotient bit per
// stage) in each axis behind three setup stages and two multiply stages.
// A one-entry skid register at the output lets the pipeline take one more
// transaction when the output stalls. Scale registers may be written only
// while no transaction is in flight.
module gimp_node_weight_gradient (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_idx_i,
  input  wire logic [gnwg_pkg::SCALE_W-1:0]        cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [gnwg_pkg::POS_W-1:0]   pos_x_i,
  input  wire logic signed [gnwg_pkg::POS_W-1:0]   pos_y_i,
  input  wire logic [gnwg_pkg::HALF_W-1:0]         half_size_x_i,
  input  wire logic [gnwg_pkg::HALF_W-1:0]         half_size_y_i,
  input  wire logic [3:0]                          node_code_i,
  input  wire logic                                want_gradient_i,
  input  wire logic                                last_node_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [gnwg_pkg::WEIGHT_W-1:0]            weight_o,
  output logic signed [gnwg_pkg::GRAD_W-1:0]       grad_x_o,
  output logic signed [gnwg_pkg::GRAD_W-1:0]       grad_y_o,
  output logic                                     last_out_o
);

  localparam int unsigned ND = gnwg_pkg::PIPE_DEPTH;
  localparam int unsigned AL = gnwg_pkg::AXIS_LAT;

  typedef struct packed {
    logic valid;
    logic want;
    logic last;
  } pv_t;

  logic [gnwg_pkg::SCALE_W-1:0] x_scale_q, y_scale_q;
  pv_t                          pv_q [ND];
  logic                         en;
  gnwg_pkg::axis_res_t          ax, ay;
  logic [gnwg_pkg::WEIGHT_W-1:0]      w_pipe;
  logic signed [gnwg_pkg::GRAD_W-1:0] gx_pipe, gy_pipe;
  logic                         skid_v_q;
  logic [gnwg_pkg::WEIGHT_W-1:0]      skid_w_q;
  logic signed [gnwg_pkg::GRAD_W-1:0] skid_gx_q, skid_gy_q;
  logic                         skid_l_q;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_scale_q <= gnwg_pkg::SCALE_RESET;
      y_scale_q <= gnwg_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gnwg_pkg::CFG_X_SCALE: x_scale_q <= cfg_data_i;
        gnwg_pkg::CFG_Y_SCALE: y_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ND; k++) begin
        pv_q[k] <= '0;
      end
    end else if (en) begin
      pv_q[0] <= '{valid: in_valid_i, want: want_gradient_i, last: last_node_i};
      for (int k = 1; k < ND; k++) begin
        pv_q[k] <= pv_q[k-1];
      end
    end
  end

  gnwg_axis u_axis_x (
    .clk_i       (clk_i),
    .en_i        (en),
    .pos_i       (pos_x_i),
    .half_size_i (half_size_x_i),
    .off_i       (gnwg_pkg::NODE_OFF_X[node_code_i]),
    .res_o       (ax)
  );

  gnwg_axis u_axis_y (
    .clk_i       (clk_i),
    .en_i        (en),
    .pos_i       (pos_y_i),
    .half_size_i (half_size_y_i),
    .off_i       (gnwg_pkg::NODE_OFF_Y[node_code_i]),
    .res_o       (ay)
  );

  gnwg_back u_back (
    .clk_i     (clk_i),
    .en_i      (en),
    .ax_i      (ax),
    .ay_i      (ay),
    .want_i    (pv_q[AL-1].want),
    .x_scale_i (x_scale_q),
    .y_scale_i (y_scale_q),
    .weight_o  (w_pipe),
    .grad_x_o  (gx_pipe),
    .grad_y_o  (gy_pipe)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (!out_stall_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (out_stall_i && pv_q[ND-1].valid) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) begin
      skid_w_q  <= w_pipe;
      skid_gx_q <= gx_pipe;
      skid_gy_q <= gy_pipe;
      skid_l_q  <= pv_q[ND-1].last;
    end
  end

  assign out_valid_o = skid_v_q || pv_q[ND-1].valid;
  assign weight_o    = skid_v_q ? skid_w_q  : w_pipe;
  assign grad_x_o    = skid_v_q ? skid_gx_q : gx_pipe;
  assign grad_y_o    = skid_v_q ? skid_gy_q : gy_pipe;
  assign last_out_o  = skid_v_q ? skid_l_q  : pv_q[ND-1].last;

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> weight_o <= gnwg_pkg::WEIGHT_W'(65536))
    else $error("weight above one");

  a_grad_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> grad_x_o != {1'b1, {(gnwg_pkg::GRAD_W-1){1'b0}}})
    else $error("grad_x beyond saturation");

  a_grad_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> grad_y_o != {1'b1, {(gnwg_pkg::GRAD_W-1){1'b0}}})
    else $error("grad_y beyond saturation");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skid_v_q ##1 skid_v_q |-> $past(out_stall_i && pv_q[ND-1].valid))
    else $error("skid filled without a stalled result");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_stall_i |=> !skid_v_q)
    else $error("skid not drained");

endmodule
`default_nettype wire

@@ test/gimp_node_weight_gradient_test.sv @@
module gimp_node_weight_gradient_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_BITS = gnwg_pkg::FRAC_BITS;
  localparam int unsigned POS_W = gnwg_pkg::POS_W;
  localparam int unsigned HALF_W = gnwg_pkg::HALF_W;
  localparam int unsigned WEIGHT_W = gnwg_pkg::WEIGHT_W;
  localparam int unsigned GRAD_W = gnwg_pkg::GRAD_W;
  localparam int unsigned SCALE_W = gnwg_pkg::SCALE_W;
  localparam int unsigned ONE = 1 << FRAC_BITS;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 480;

  typedef struct {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [HALF_W-1:0]       half_x;
    logic [HALF_W-1:0]       half_y;
    logic [3:0]              code;
    logic                    want;
    logic                    last;
  } node_item_t;

  typedef struct {
    logic [WEIGHT_W-1:0] weight;
    logic [GRAD_W-1:0]   grad_x;
    logic [GRAD_W-1:0]   grad_y;
    logic                last;
  } node_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic                       cfg_idx_i = gnwg_pkg::CFG_X_SCALE;
  logic [SCALE_W-1:0]         cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [POS_W-1:0]    pos_x_i = '0;
  logic signed [POS_W-1:0]    pos_y_i = '0;
  logic [HALF_W-1:0]          half_size_x_i = '0;
  logic [HALF_W-1:0]          half_size_y_i = '0;
  logic [3:0]                 node_code_i = '0;
  logic                       want_gradient_i = 1'b0;
  logic                       last_node_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [WEIGHT_W-1:0]        weight_o;
  logic signed [GRAD_W-1:0]   grad_x_o;
  logic signed [GRAD_W-1:0]   grad_y_o;
  logic                       last_out_o;

  node_item_t   pending_nodes[$];
  node_result_t expected_results[$];
  logic [SCALE_W-1:0] scale_x = gnwg_pkg::SCALE_RESET;
  logic [SCALE_W-1:0] scale_y = gnwg_pkg::SCALE_RESET;
  int  mismatches = 0;
  int  cycles = 0;
  int  tx_idle = 0;
  int  rx_idle = 0;
  int  phase = 0;
  bit  running = 1'b0;
  logic taken = 1'b0;
  logic hold = 1'b0;

  gimp_node_weight_gradient uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void axis_value(input longint d, input longint h,
                                     output longint s, output longint ds);
    longint num, v, r;
    if (d < h) begin
      num = (4 * longint'(ONE) - h) * h - d * d;
      v = num > 0 ? num / (4 * h) : 0;
      s = v > ONE ? ONE : v;
      ds = (d << FRAC_BITS) / (2 * h);
    end else if (d <= 2 * longint'(ONE) - h) begin
      s = (2 * longint'(ONE) - d) / 2;
      ds = ONE / 2;
    end else if (d < 2 * longint'(ONE) + h) begin
      r = 2 * longint'(ONE) + h - d;
      v = (r * r) / (8 * h);
      s = v > ONE ? ONE : v;
      ds = (r << FRAC_BITS) / (4 * h);
    end else begin
      s = 0;
      ds = 0;
    end
  endfunction

  function automatic logic [GRAD_W-1:0] slope_term(bit pos_side, longint ds, longint s_other,
                                                   longint scale);
    longint m;
    m = (ds * s_other) >> FRAC_BITS;
    m = (m * scale) >> FRAC_BITS;
    if (m > 16777215) m = 16777215;
    return pos_side ? GRAD_W'(-m) : GRAD_W'(m);
  endfunction

  function automatic node_result_t node_weight(node_item_t it);
    node_result_t res;
    longint px, py, ox, oy, dx, dy, hx, hy, sx, sy, dsx, dsy, w;
    px = it.pos_x;
    py = it.pos_y;
    ox = longint'(gnwg_pkg::NODE_OFF_X[it.code]) * ONE;
    oy = longint'(gnwg_pkg::NODE_OFF_Y[it.code]) * ONE;
    dx = px > ox ? px - ox : ox - px;
    dy = py > oy ? py - oy : oy - py;
    hx = it.half_x == 0 ? 1 : longint'(it.half_x);
    hy = it.half_y == 0 ? 1 : longint'(it.half_y);
    axis_value(dx, hx, sx, dsx);
    axis_value(dy, hy, sy, dsy);
    w = (sx * sy) >> FRAC_BITS;
    res.weight = w > 131071 ? 17'h1FFFF : WEIGHT_W'(w);
    res.grad_x = it.want ? slope_term(px > ox, dsx, sy, longint'(scale_x)) : '0;
    res.grad_y = it.want ? slope_term(py > oy, dsy, sx, longint'(scale_y)) : '0;
    res.last = it.last;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %0h expected %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // transaction capture and prediction
  always @(posedge clk_i) begin
    node_item_t it;
    node_result_t want_res;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("gimp_node_weight_gradient verification failed");
      $finish;
    end
    taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      it.pos_x = pos_x_i;
      it.pos_y = pos_y_i;
      it.half_x = half_size_x_i;
      it.half_y = half_size_y_i;
      it.code = node_code_i;
      it.want = want_gradient_i;
      it.last = last_node_i;
      expected_results.push_back(node_weight(it));
    end
    if (out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", weight_o, 0);
      end else begin
        want_res = expected_results.pop_front();
        if (weight_o !== want_res.weight) report_mismatch("weight", weight_o, want_res.weight);
        if (grad_x_o !== want_res.grad_x) report_mismatch("grad_x", grad_x_o, want_res.grad_x);
        if (grad_y_o !== want_res.grad_y) report_mismatch("grad_y", grad_y_o, want_res.grad_y);
        if (last_out_o !== want_res.last) report_mismatch("last_out", last_out_o, want_res.last);
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    node_item_t it;
    out_stall_i <= hold || ($urandom_range(99) < rx_idle);
    if (!in_valid_i || taken) begin
      if (running && pending_nodes.size() > 0 && $urandom_range(99) >= tx_idle) begin
        it = pending_nodes.pop_front();
        pos_x_i <= it.pos_x;
        pos_y_i <= it.pos_y;
        half_size_x_i <= it.half_x;
        half_size_y_i <= it.half_y;
        node_code_i <= it.code;
        want_gradient_i <= it.want;
        last_node_i <= it.last;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver hold-off while the sender keeps going
  initial begin
    wait (phase == 2);
    repeat (20) @(posedge clk_i);
    hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold <= 1'b0;
  end

  task automatic add_node(int px, int py, int hx, int hy, int code, bit want, bit last);
    node_item_t it;
    it.pos_x = POS_W'(px);
    it.pos_y = POS_W'(py);
    it.half_x = HALF_W'(hx);
    it.half_y = HALF_W'(hy);
    it.code = 4'(code);
    it.want = want;
    it.last = last;
    pending_nodes.push_back(it);
  endtask

  function automatic int pick_pos();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return $urandom_range(262143) - 131072;
    if (sel == 1) return ($urandom_range(1) ? 65536 : -65536);
    return $urandom_range(131072) - 65536;
  endfunction

  function automatic int pick_half();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 0;
    if (sel == 1) return $urandom_range(131071);
    if (sel < 5) return $urandom_range(4096);
    return $urandom_range(65536);
  endfunction

  task automatic add_particles(int count);
    int px, py, hx, hy, n, first, k;
    bit want;
    k = 0;
    while (k < count) begin
      if ($urandom_range(9) == 0) begin
        add_node(pick_pos(), pick_pos(), pick_half(), pick_half(), $urandom_range(15),
                 $urandom_range(1), $urandom_range(1));
        k++;
      end else begin
        px = pick_pos();
        py = pick_pos();
        hx = pick_half();
        hy = pick_half();
        want = $urandom_range(4) != 0;
        n = $urandom_range(1) ? 16 : 4;
        first = n == 16 ? 0 : 0;
        for (int c = first; c < n; c++) begin
          add_node(px, py, hx, hy, c, want, c == n - 1);
          k++;
        end
      end
    end
  endtask

  task automatic write_scales(logic [SCALE_W-1:0] sx, logic [SCALE_W-1:0] sy);
    wait (pending_nodes.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (gnwg_pkg::PIPE_DEPTH + 4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= gnwg_pkg::CFG_X_SCALE;
    cfg_data_i <= sx;
    @(negedge clk_i);
    cfg_idx_i <= gnwg_pkg::CFG_Y_SCALE;
    cfg_data_i <= sy;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    scale_x = sx;
    scale_y = sy;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_scales(SCALE_W'(1), SCALE_W'(16777216));
    tx_idle = 13;
    rx_idle = 75;
    for (int c = 0; c < 16; c++)
      add_node((c % 3 - 1) * 65536, (c % 5 - 2) * 32768, c * 4096, 65536 - c * 4096, c,
               c % 4 != 0, c == 15);
    add_node(65536, -65536, 0, 0, 1, 1'b1, 1'b0);
    add_node(-131072, 131071, 131071, 131071, 7, 1'b1, 1'b1);
    add_node(0, 0, 65536, 65536, 0, 1'b1, 1'b0);
    add_node(-65536, -65536, 1, 1, 0, 1'b1, 1'b0);
    add_node(-32768, -65536, 16384, 1, 5, 1'b1, 1'b0);
    add_node(32768, 98304, 32768, 32768, 2, 1'b0, 1'b1);
    add_particles(ITEMS_PER_PHASE);
    running = 1'b1;

    write_scales(SCALE_W'(16777216), SCALE_W'(0));
    tx_idle = 75;
    rx_idle = 13;
    add_particles(ITEMS_PER_PHASE);

    write_scales(SCALE_W'($urandom_range(16777216, 1)), gnwg_pkg::SCALE_RESET);
    tx_idle = 0;
    rx_idle = 0;
    add_particles(ITEMS_PER_PHASE);
    phase = 2;

    wait (pending_nodes.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (gnwg_pkg::PIPE_DEPTH + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("gimp_node_weight_gradient verification clean");
    end else begin
      $display("gimp_node_weight_gradient verification failed");
    end
    $finish;
  end

endmodule
